### src/lfu_pkg.sv
// Shared constants and command codes for the LFU slot replacement core.
package lfu_pkg;

   localparam int KEY_W         = 7;
   localparam int CNT_W         = 16;
   localparam int STAMP_W       = 32;
   localparam int CSR_W         = 6;
   localparam int KEY_RANGE     = 128;
   localparam int MAX_SLOTS_DEF = 32;
   localparam int REQ_TDATA_W   = 8;
   localparam int RSP_TDATA_W   = 40;

   localparam logic [CSR_W-1:0]   CSR_RESET = CSR_W'(20);
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
   localparam logic [STAMP_W-1:0] SEQ_MAX   = '1;

   typedef enum logic {
      CMD_INC  = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_kind_type;

   typedef enum logic {
      OP_VOTE   = 1'b0,
      OP_REPORT = 1'b1
   } op_type;

endpackage

### src/lfu_slot_replacement_core.sv
// Top level: request control, chain of slot cells, result register and limit register.
//
//  channel | ports                         | contents
//  --------+-------------------------------+-------------------------------------------
//  request | req_tvalid/tready/tdata/tuser | tdata: key_id; tuser: op
//  result  | rsp_tvalid/tready/tdata/tlast | tdata: hit..listed_id; tlast: last
//  config  | csr_we/csr_wdata              | slots_in_use
//
// A scan word walks the cell chain, one cell per cycle: a vote passes the launch register,
// every cell and the scan result register before its result is registered, and the next
// request is taken once the controller is back in idle. A report makes one chain pass per
// listed key. Reset is synchronous and empties the table. A stalled result holds the
// controller in its result state; no request is taken until the last result of the item
// is registered.
module lfu_slot_replacement_core
   import lfu_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [6:0] key_id, rest zero
   input  logic                   req_tuser,   // [0] op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // hit, evicted_valid, evicted_id[7],
                                               // count_now[16], listed_present,
                                               // listed_id[7], zero fill
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_W-1:0]       csr_wdata
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int RES_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = ((RES_W > CSR_W) ? RES_W : CSR_W) + 1;
   localparam int TOK_W = IDX_W*3 + RES_W + KEY_W*3 + CNT_W*2 + STAMP_W + 7;
   localparam int CMD_W = IDX_W + KEY_W + STAMP_W + 2;
   localparam logic [CMP_W-1:0] LIM_MAX = CMP_W'(MAX_SLOTS);

   typedef struct packed {
      logic              valid;
      logic              report;
      logic              have_prev;
      logic [KEY_W-1:0]  key;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [CNT_W-1:0]  hit_cnt;
      logic [RES_W-1:0]  res;
      logic              free_found;
      logic [IDX_W-1:0]  free_idx;
      logic              vic_found;
      logic [IDX_W-1:0]  vic_idx;
      logic [CNT_W-1:0]  vic_cnt;
      logic [STAMP_W-1:0] vic_stamp;
      logic [KEY_W-1:0]  vic_key;
      logic              found;
      logic [KEY_W-1:0]  best;
   } token_type;

   typedef struct packed {
      logic               we;
      cmd_kind_type       kind;
      logic [IDX_W-1:0]   idx;
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
   } cmd_type;

   typedef struct packed {
      logic             hit;
      logic             ev_valid;
      logic [KEY_W-1:0] ev_id;
      logic [CNT_W-1:0] count_now;
      logic             listed_present;
      logic [KEY_W-1:0] listed_id;
      logic             last;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [CSR_W-1:0]   slots_ff;
   logic [STAMP_W-1:0] seq_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic [KEY_W-1:0]   key_ff;
   logic               bad_ff;
   token_type          launch_ff;
   token_type          launch_in;
   token_type          done_ff;
   logic               rsp_valid_ff;
   result_type         rsp_ff;

   logic [TOK_W-1:0]   chain [MAX_SLOTS+1];
   token_type          chain_end;
   cmd_type            cmd;
   result_type         res_in;
   logic [CMP_W-1:0]   limit;
   logic               out_free;
   logic               req_xfer;
   logic               req_key_ok;
   logic               req_report;
   logic               relaunch;
   logic [KEY_W-1:0]   req_key;

   assign req_key    = req_tdata[KEY_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign req_key_ok = int'(req_key) < KEY_RANGE;
   assign req_report = (op_type'(req_tuser) == OP_REPORT);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign chain[0]   = launch_ff;
   assign chain_end  = token_type'(chain[MAX_SLOTS]);

   genvar gi;
   generate
      for (gi = 0; gi < MAX_SLOTS; gi++) begin : g_cell
         lfu_cell #(
            .MAX_SLOTS (MAX_SLOTS),
            .CELL_IDX  (gi)
         ) u_cell (
            .clock (clock),
            .reset (reset),
            .cmd_i (CMD_W'(cmd)),
            .tok_i (chain[gi]),
            .tok_o (chain[gi+1])
         );
      end
   endgenerate

   always_comb begin
      if (slots_ff == '0) begin
         limit = CMP_W'(1);
      end else if (CMP_W'(slots_ff) > LIM_MAX) begin
         limit = LIM_MAX;
      end else begin
         limit = CMP_W'(slots_ff);
      end
   end

   always_comb begin
      res_in    = '0;
      res_in.last = 1'b1;
      cmd       = '0;
      cmd.key   = key_ff;
      cmd.stamp = stamp_ff;
      relaunch  = 1'b0;
      if (bad_ff) begin
         res_in.last = 1'b1;
      end else if (done_ff.report) begin
         if (done_ff.found) begin
            res_in.listed_present = 1'b1;
            res_in.listed_id      = done_ff.best;
            res_in.last           = (done_ff.res == RES_W'(1));
            relaunch              = (done_ff.res != RES_W'(1));
         end
      end else begin
         priority if (done_ff.hit) begin
            res_in.hit       = 1'b1;
            res_in.count_now = done_ff.hit_cnt;
            cmd.we           = 1'b1;
            cmd.kind         = CMD_INC;
            cmd.idx          = done_ff.hit_idx;
         end else if (CMP_W'(done_ff.res) < limit && done_ff.free_found) begin
            res_in.count_now = CNT_W'(1);
            cmd.we           = 1'b1;
            cmd.kind         = CMD_LOAD;
            cmd.idx          = done_ff.free_idx;
         end else if (done_ff.vic_found) begin
            res_in.ev_valid  = 1'b1;
            res_in.ev_id     = done_ff.vic_key;
            res_in.count_now = CNT_W'(1);
            cmd.we           = 1'b1;
            cmd.kind         = CMD_LOAD;
            cmd.idx          = done_ff.vic_idx;
         end else begin
            res_in.last = 1'b1;
         end
      end
      cmd.we = cmd.we && (state_ff == ST_DONE) && out_free;
   end

   // one-cycle scan word launch: new request, or next pass of a report
   always_comb begin
      launch_in     = '0;
      launch_in.key = req_key;
      if (state_ff == ST_IDLE) begin
         launch_in.valid  = req_xfer && (req_report || req_key_ok);
         launch_in.report = req_report;
      end else if (state_ff == ST_DONE && out_free && relaunch) begin
         launch_in.valid     = 1'b1;
         launch_in.report    = 1'b1;
         launch_in.have_prev = 1'b1;
         launch_in.key       = done_ff.best;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slots_ff     <= CSR_RESET;
         seq_ff       <= '0;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         launch_ff <= launch_in;
         if (csr_we) begin
            slots_ff <= csr_wdata;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= res_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  key_ff   <= req_key;
                  stamp_ff <= seq_ff;
                  if (req_report) begin
                     bad_ff   <= 1'b0;
                     state_ff <= ST_SCAN;
                  end else if (req_key_ok) begin
                     bad_ff <= 1'b0;
                     if (seq_ff != SEQ_MAX) begin
                        seq_ff <= seq_ff + 1'b1;
                     end
                     state_ff <= ST_SCAN;
                  end else begin
                     bad_ff   <= 1'b1;
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_SCAN: begin
               if (chain_end.valid) begin
                  done_ff  <= chain_end;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  if (relaunch) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {7'b0, rsp_ff.listed_id, rsp_ff.listed_present, rsp_ff.count_now,
                        rsp_ff.ev_id, rsp_ff.ev_valid, rsp_ff.hit};

endmodule

### src/lfu_cell.sv
// One slot of the table: holds a resident entry and folds it into the passing scan word.
module lfu_cell
   import lfu_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF,
   parameter int CELL_IDX  = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)+KEY_W+STAMP_W+1:0] cmd_i,
   input  logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)*3+$clog2(MAX_SLOTS+1)
                 +KEY_W*3+CNT_W*2+STAMP_W+6:0] tok_i,
   output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)*3+$clog2(MAX_SLOTS+1)
                 +KEY_W*3+CNT_W*2+STAMP_W+6:0] tok_o
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int RES_W = $clog2(MAX_SLOTS + 1);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   typedef struct packed {
      logic              valid;
      logic              report;
      logic              have_prev;
      logic [KEY_W-1:0]  key;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [CNT_W-1:0]  hit_cnt;
      logic [RES_W-1:0]  res;
      logic              free_found;
      logic [IDX_W-1:0]  free_idx;
      logic              vic_found;
      logic [IDX_W-1:0]  vic_idx;
      logic [CNT_W-1:0]  vic_cnt;
      logic [STAMP_W-1:0] vic_stamp;
      logic [KEY_W-1:0]  vic_key;
      logic              found;
      logic [KEY_W-1:0]  best;
   } token_type;

   typedef struct packed {
      logic               we;
      cmd_kind_type       kind;
      logic [IDX_W-1:0]   idx;
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
   } cmd_type;

   token_type t_in;
   token_type tok_in;
   token_type tok_ff;
   cmd_type   cmd;

   logic               slot_valid_ff;
   logic [KEY_W-1:0]   slot_key_ff;
   logic [CNT_W-1:0]   slot_count_ff;
   logic [STAMP_W-1:0] slot_stamp_ff;
   logic [CNT_W-1:0]   cnt_sat;

   assign t_in  = token_type'(tok_i);
   assign cmd   = cmd_type'(cmd_i);
   assign tok_o = tok_ff;
   assign cnt_sat = (slot_count_ff == CNT_MAX) ? slot_count_ff : slot_count_ff + 1'b1;

   always_comb begin
      tok_in = t_in;
      if (t_in.valid && slot_valid_ff) begin
         if (t_in.report) begin
            if (!t_in.have_prev || slot_key_ff > t_in.key) begin
               tok_in.res = t_in.res + 1'b1;
               if (!t_in.found || slot_key_ff < t_in.best) begin
                  tok_in.found = 1'b1;
                  tok_in.best  = slot_key_ff;
               end
            end
         end else begin
            tok_in.res = t_in.res + 1'b1;
            if (!t_in.hit && slot_key_ff == t_in.key) begin
               tok_in.hit     = 1'b1;
               tok_in.hit_idx = MY_IDX;
               tok_in.hit_cnt = cnt_sat;
            end
            if (!t_in.vic_found || slot_count_ff < t_in.vic_cnt ||
                (slot_count_ff == t_in.vic_cnt && slot_stamp_ff < t_in.vic_stamp)) begin
               tok_in.vic_found = 1'b1;
               tok_in.vic_idx   = MY_IDX;
               tok_in.vic_cnt   = slot_count_ff;
               tok_in.vic_stamp = slot_stamp_ff;
               tok_in.vic_key   = slot_key_ff;
            end
         end
      end else if (t_in.valid && !t_in.report && !t_in.free_found) begin
         tok_in.free_found = 1'b1;
         tok_in.free_idx   = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff        <= '0;
         slot_valid_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         if (cmd.we && cmd.idx == MY_IDX && cmd.kind == CMD_LOAD) begin
            slot_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.we && cmd.idx == MY_IDX) begin
         unique case (cmd.kind)
            CMD_INC: begin
               slot_count_ff <= cnt_sat;
            end
            CMD_LOAD: begin
               slot_key_ff   <= cmd.key;
               slot_count_ff <= CNT_W'(1);
               slot_stamp_ff <= cmd.stamp;
            end
            default: begin
               slot_count_ff <= slot_count_ff;
            end
         endcase
      end
   end

endmodule
